// ===== rtl/cst_pkg.sv =====
package cst_pkg;

	// Built size of the belt and of each position.
	localparam int MAX_POSITIONS = 32;
	localparam int SLOT_CAPACITY = 4;
	localparam int TYPE_COUNT    = 4;
	localparam int TAG_BITS      = 16;

	// Widths that follow from the built size.
	localparam int POS_W  = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
	localparam int LEN_W  = $clog2(MAX_POSITIONS + 1);
	localparam int FILL_W = $clog2(SLOT_CAPACITY + 1);
	localparam int IDX_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
	localparam int TSEL_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

	// Fixed field widths of the request and result.
	localparam int OP_W     = 2;
	localparam int POS_IN_W = 5;
	localparam int TYPE_W   = 3;
	localparam int TAG_IN_W = 16;
	localparam int CFG_W    = 6;
	localparam int STATUS_W = 2;
	localparam int DROP_W   = 3;
	localparam int CNT_W    = 32;
	localparam int CMP_W    = (LEN_W > POS_IN_W) ? LEN_W : POS_IN_W;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 2'd0,
		OP_REMOVE = 2'd1,
		OP_TICK   = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	// Contents of one belt position.
	typedef struct packed {
		logic [FILL_W-1:0]                       fill;
		logic [SLOT_CAPACITY-1:0][TYPE_W-1:0]    ptype;
		logic [SLOT_CAPACITY-1:0][TAG_BITS-1:0]  tag;
	} slot_t;

	// Per-cell command strobes for one request.
	typedef struct packed {
		logic clear;
		logic load;
		logic add;
		logic remove;
	} cell_cmd_t;

	// Request payload, first field in the lowest bits.
	typedef struct packed {
		logic [3:0]          pad;
		logic                match_any;
		logic [TYPE_W-1:0]   wanted_type;
		logic [TAG_IN_W-1:0] piece_tag;
		logic [TYPE_W-1:0]   piece_type;
		logic [POS_IN_W-1:0] position;
	} in_data_t;

	// Result payload, first field in the lowest bits.
	typedef struct packed {
		logic [CNT_W-1:0]    type_bin_count;
		logic [CNT_W-1:0]    bin_total;
		logic [DROP_W-1:0]   dropped_count;
		logic [TYPE_W-1:0]   found_type;
		logic [STATUS_W-1:0] status;
	} out_data_t;

	localparam int IN_DATA_W  = $bits(in_data_t);
	localparam int OUT_DATA_W = $bits(out_data_t);

endpackage

// ===== rtl/cst_cell.sv =====
module cst_cell import cst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_cmd_t           cmd,
	input  slot_t               prev,
	input  logic [TYPE_W-1:0]   add_type,
	input  logic [TAG_BITS-1:0] add_tag,
	input  logic [TYPE_W-1:0]   want_type,
	input  logic                want_any,
	output slot_t               slot,
	output logic                hit,
	output logic [TYPE_W-1:0]   hit_type
);

	logic [FILL_W-1:0]                      fill_q;
	logic [SLOT_CAPACITY-1:0][TYPE_W-1:0]   type_q;
	logic [SLOT_CAPACITY-1:0][TAG_BITS-1:0] tag_q;
	logic [IDX_W-1:0]                       hit_idx;
	logic [IDX_W-1:0]                       fill_idx;
	logic                                   add_ok;

	assign slot     = '{fill: fill_q, ptype: type_q, tag: tag_q};
	assign add_ok   = fill_q < FILL_W'(SLOT_CAPACITY);
	assign fill_idx = IDX_W'(fill_q);

	// Find the first stored item that matches; lower entries win.
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int k = SLOT_CAPACITY - 1; k >= 0; k--) begin
			if (FILL_W'(k) < fill_q && (want_any || type_q[k] == want_type)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(k);
			end
		end
	end

	assign hit_type = type_q[hit_idx];

	// Item count of this position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			priority if (cmd.clear) begin
				fill_q <= '0;
			end else if (cmd.load) begin
				fill_q <= prev.fill;
			end else if (cmd.add && add_ok) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (cmd.remove && hit) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	// Item storage: take the neighbor's items, append, or close the gap.
	always_ff @(posedge clk) begin
		priority if (cmd.load) begin
			type_q <= prev.ptype;
			tag_q  <= prev.tag;
		end else if (cmd.add && add_ok) begin
			type_q[fill_idx] <= add_type;
			tag_q[fill_idx]  <= add_tag;
		end else if (cmd.remove && hit) begin
			for (int k = 0; k < SLOT_CAPACITY - 1; k++) begin
				if (IDX_W'(k) >= hit_idx) begin
					type_q[k] <= type_q[k + 1];
					tag_q[k]  <= tag_q[k + 1];
				end
			end
		end
	end

endmodule

// ===== rtl/cst_bin.sv =====
module cst_bin import cst_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  slot_t             last_slot,
	input  logic [TYPE_W-1:0] query_type,
	output logic [DROP_W-1:0] dropped,
	output logic [CNT_W-1:0]  total,
	output logic [CNT_W-1:0]  type_total
);

	logic [TYPE_COUNT-1:0][CNT_W-1:0]  bin_q;
	logic [CNT_W-1:0]                  sum_q;
	logic [TYPE_COUNT-1:0][FILL_W-1:0] type_cnt;
	logic [FILL_W-1:0]                 drop_cnt;
	logic [TYPE_COUNT-1:0][CNT_W-1:0]  bin_next;
	logic [CNT_W-1:0]                  sum_next;
	logic [TSEL_W-1:0]                 tsel;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
	                                             input logic [FILL_W-1:0] d);
		logic [CNT_W:0] s;
		s = {1'b0, v} + (CNT_W + 1)'(d);
		return s[CNT_W] ? '1 : s[CNT_W-1:0];
	endfunction

	// Count the countable items of the position that falls off the belt.
	always_comb begin
		type_cnt = '0;
		drop_cnt = '0;
		for (int k = 0; k < SLOT_CAPACITY; k++) begin
			for (int t = 0; t < TYPE_COUNT; t++) begin
				if (FILL_W'(k) < last_slot.fill && last_slot.ptype[k] == TYPE_W'(t + 1)) begin
					type_cnt[t] = type_cnt[t] + FILL_W'(1);
					drop_cnt    = drop_cnt + FILL_W'(1);
				end
			end
		end
	end

	// Saturating counter updates.
	always_comb begin
		for (int t = 0; t < TYPE_COUNT; t++) begin
			bin_next[t] = tick ? sat_add(bin_q[t], type_cnt[t]) : bin_q[t];
		end
		sum_next = tick ? sat_add(sum_q, drop_cnt) : sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_q <= '0;
			sum_q <= '0;
		end else if (tick) begin
			bin_q <= bin_next;
			sum_q <= sum_next;
		end
	end

	// Values as they stand after this request.
	assign tsel       = TSEL_W'(query_type - TYPE_W'(1));
	assign dropped    = tick ? DROP_W'(drop_cnt) : '0;
	assign total      = sum_next;
	assign type_total = (query_type != '0 && query_type <= TYPE_W'(TYPE_COUNT)) ?
	                    bin_next[tsel] : '0;

endmodule

// ===== rtl/conveyor_slot_tracker.sv =====
// Channel  | Direction | Payload
// s_*      | in        | tuser: operation; tdata: request fields
// m_*      | out       | tdata: one result per request
// cfg_*    | in        | belt_length, written when cfg_we is high
//
// A request is applied to the row of position cells at the edge that accepts
// it, and its result sits in the output register the next cycle, so one
// request per cycle is sustained when m_tready is high. The path that sets
// the cycle is the last-position select feeding the bin counters. Reset
// clears all counts, the bin and the output valid, and loads belt_length
// 32. s_tready is low only while a result is stalled.
module conveyor_slot_tracker import cst_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// operation
	input  logic [OP_W-1:0]       s_tuser,
	// position, piece_type, piece_tag, wanted_type, match_any, zero pad
	input  logic [IN_DATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// status, found_type, dropped_count, bin_total, type_bin_count
	output logic [OUT_DATA_W-1:0] m_tdata,
	input  logic                  cfg_we,
	input  logic [CFG_W-1:0]      cfg_wdata
);

	in_data_t                  req;
	op_t                       op;
	logic                      accept;
	logic [LEN_W-1:0]          len_q;
	logic [POS_W-1:0]          last_q;
	logic [POS_W-1:0]          pos_idx;
	logic                      in_range;
	slot_t                     slots [MAX_POSITIONS];
	slot_t                     prev_slots [MAX_POSITIONS];
	logic [MAX_POSITIONS-1:0]  hits;
	logic [TYPE_W-1:0]         hit_types [MAX_POSITIONS];
	slot_t                     sel_slot;
	logic                      sel_full;
	logic                      remove_ok;
	logic                      tick;
	logic [DROP_W-1:0]         dropped;
	logic [CNT_W-1:0]          total;
	logic [CNT_W-1:0]          type_total;
	out_data_t                 res;
	logic                      m_tvalid_q;
	out_data_t                 out_q;

	function automatic logic [LEN_W-1:0] eff_len(input logic [CFG_W-1:0] v);
		if (v == '0) begin
			return LEN_W'(1);
		end
		if (int'(v) > MAX_POSITIONS) begin
			return LEN_W'(MAX_POSITIONS);
		end
		return LEN_W'(v);
	endfunction

	assign req    = in_data_t'(s_tdata);
	assign op     = op_t'(s_tuser);
	assign accept = s_tvalid && s_tready;

	// Belt length is kept in its effective form, with the last index beside it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(MAX_POSITIONS);
			last_q <= POS_W'(MAX_POSITIONS - 1);
		end else if (cfg_we) begin
			len_q  <= eff_len(cfg_wdata);
			last_q <= POS_W'(eff_len(cfg_wdata) - LEN_W'(1));
		end
	end

	assign pos_idx  = POS_W'(req.position);
	assign in_range = CMP_W'(req.position) < CMP_W'(len_q);

	// Row of position cells; on a tick cell 0 clears, each later cell in use takes its neighbor's items.
	for (genvar i = 0; i < MAX_POSITIONS; i++) begin : g_cell
		cell_cmd_t cmd;

		if (i == 0) begin : g_head
			assign prev_slots[i] = '0;
		end else begin : g_body
			assign prev_slots[i] = slots[i - 1];
		end

		assign cmd.clear  = accept && op == OP_TICK && i == 0;
		assign cmd.load   = accept && op == OP_TICK && i != 0 && POS_W'(i) <= last_q;
		assign cmd.add    = accept && op == OP_ADD && in_range && pos_idx == POS_W'(i);
		assign cmd.remove = accept && op == OP_REMOVE && in_range && pos_idx == POS_W'(i);

		cst_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.prev      (prev_slots[i]),
			.add_type  (req.piece_type),
			.add_tag   (TAG_BITS'(req.piece_tag)),
			.want_type (req.wanted_type),
			.want_any  (req.match_any),
			.slot      (slots[i]),
			.hit       (hits[i]),
			.hit_type  (hit_types[i])
		);
	end

	assign sel_slot  = slots[pos_idx];
	assign sel_full  = sel_slot.fill >= FILL_W'(SLOT_CAPACITY);
	assign remove_ok = in_range && hits[pos_idx];
	assign tick      = accept && op == OP_TICK;

	// Bin counters fed by the last position in use.
	cst_bin u_bin (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick),
		.last_slot  (slots[last_q]),
		.query_type (req.piece_type),
		.dropped    (dropped),
		.total      (total),
		.type_total (type_total)
	);

	// Result of the current request.
	always_comb begin
		res                = '0;
		res.dropped_count  = dropped;
		res.bin_total      = total;
		res.type_bin_count = type_total;
		unique case (op)
			OP_ADD: begin
				res.status = (in_range && !sel_full) ? ST_OK : ST_FULL;
			end
			OP_REMOVE: begin
				res.status     = remove_ok ? ST_OK : ST_NOT_FOUND;
				res.found_type = remove_ok ? hit_types[pos_idx] : '0;
			end
			OP_TICK, OP_NOP: begin
				res.status = ST_OK;
			end
		endcase
	end

	// Output register; a stalled result keeps its place while nothing new enters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	assign s_tready = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

endmodule

// ===== rtl/cst_checker.sv =====
module cst_checker import cst_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata
);

	out_data_t res;

	assign res = out_data_t'(m_tdata);

	// A stalled result stays valid and unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// Every accepted request shows a result in the next cycle.
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted request gave no result");

	// With the output register empty a request is always taken.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("request refused while output register empty");

	// A failed request reports no removed item.
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.status != ST_OK |-> res.found_type == '0)
		else $error("found type on a failed request");

	// Items dropped into the bin come only from a tick.
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res.dropped_count != '0 |-> res.status == ST_OK && res.found_type == '0)
		else $error("dropped count on a request that is not a tick");

endmodule

bind conveyor_slot_tracker cst_checker u_cst_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
	import cst_pkg::*;

	localparam int CLK_HALF     = 6;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int PHASE_ITEMS  = 108;
	localparam int HOLD_CYCLES  = 400;
	localparam int NO_HIT       = -1;

	// One request as it waits for the driver.
	typedef struct {
		op_t      op;
		in_data_t data;
	} belt_req_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	// operation
	logic [OP_W-1:0]       s_tuser   = OP_NOP;
	// position, piece_type, piece_tag, wanted_type, match_any, zero pad
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	// status, found_type, dropped_count, bin_total, type_bin_count
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Predicted belt contents and bin counters.
	logic [CFG_W-1:0]    belt_len_q;
	logic [FILL_W-1:0]   cell_fill [MAX_POSITIONS];
	logic [TYPE_W-1:0]   cell_type [MAX_POSITIONS][SLOT_CAPACITY];
	logic [TAG_BITS-1:0] cell_tag  [MAX_POSITIONS][SLOT_CAPACITY];
	logic [CNT_W-1:0]    bin_type_cnt [TYPE_COUNT];
	logic [CNT_W-1:0]    bin_all_cnt;

	belt_req_t belt_requests [$];
	out_data_t belt_answers [$];

	int  n_queued     = 0;
	int  n_accepted   = 0;
	int  n_checked    = 0;
	int  n_ticks      = 0;
	int  n_lengths    = 0;
	int  err_cnt      = 0;
	int  cycle_cnt    = 0;
	int  tx_gap       = 0;
	int  rx_gap       = 0;
	int  hold_request = 0;
	int  hold_left    = 0;
	bit  req_fired    = 1'b0;
	bit  no_idle      = 1'b0;

	logic [CFG_W-1:0] phase_len [10] = '{6'd63, 6'd2, 6'd0, 6'd33, 6'd17,
		6'd32, 6'd1, 6'd9, 6'd40, 6'd32};

	conveyor_slot_tracker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Positions in use: zero counts as one, anything above the built size saturates.
	function automatic int span_of(logic [CFG_W-1:0] v);
		if (v == 0) return 1;
		if (v > MAX_POSITIONS) return MAX_POSITIONS;
		return int'(v);
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Apply one request to the predicted belt and return the result it gives.
	function automatic out_data_t belt_apply(op_t op, in_data_t req);
		out_data_t res;
		int span;
		int p;
		int n;
		int hit;
		int last;
		res  = '0;
		span = span_of(belt_len_q);
		p    = int'(req.position);
		case (op)
			OP_ADD: begin
				if (p >= span || cell_fill[p] >= SLOT_CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					n = int'(cell_fill[p]);
					cell_type[p][n] = req.piece_type;
					cell_tag[p][n]  = req.piece_tag[TAG_BITS-1:0];
					cell_fill[p]    = FILL_W'(n + 1);
				end
			end
			OP_REMOVE: begin
				res.status = ST_NOT_FOUND;
				hit = NO_HIT;
				if (p < span) begin
					n = int'(cell_fill[p]);
					for (int k = 0; k < n; k++) begin
						if (hit == NO_HIT &&
							(req.match_any || cell_type[p][k] == req.wanted_type)) begin
							hit = k;
						end
					end
					if (hit != NO_HIT) begin
						res.status     = ST_OK;
						res.found_type = cell_type[p][hit];
						// Close the gap behind the removed piece.
						for (int k = hit; k < n - 1; k++) begin
							cell_type[p][k] = cell_type[p][k+1];
							cell_tag[p][k]  = cell_tag[p][k+1];
						end
						cell_fill[p] = FILL_W'(n - 1);
					end
				end
			end
			OP_TICK: begin
				last = span - 1;
				// Count the pieces of countable types that fall into the bin.
				for (int k = 0; k < int'(cell_fill[last]); k++) begin
					if (cell_type[last][k] >= 1 && cell_type[last][k] <= TYPE_COUNT) begin
						bin_type_cnt[cell_type[last][k] - 1] =
							sat_inc(bin_type_cnt[cell_type[last][k] - 1]);
						bin_all_cnt = sat_inc(bin_all_cnt);
						res.dropped_count = res.dropped_count + 1'b1;
					end
				end
				// Shift every position in use one place onward.
				for (int i = last; i > 0; i--) begin
					cell_fill[i] = cell_fill[i-1];
					for (int k = 0; k < SLOT_CAPACITY; k++) begin
						cell_type[i][k] = cell_type[i-1][k];
						cell_tag[i][k]  = cell_tag[i-1][k];
					end
				end
				cell_fill[0] = '0;
			end
			default: begin
			end
		endcase
		res.bin_total = bin_all_cnt;
		if (req.piece_type >= 1 && req.piece_type <= TYPE_COUNT) begin
			res.type_bin_count = bin_type_cnt[req.piece_type - 1];
		end
		return res;
	endfunction

	function automatic void check_field(string name, logic [CNT_W-1:0] want,
		logic [CNT_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			err_cnt++;
		end
	endfunction

	// Idle length: mostly none or short, now and then a long one.
	function automatic int draw_gap();
		int r;
		if (no_idle) return 0;
		r = $urandom_range(0, 99);
		if (r < 62) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic void queue_req(op_t op, logic [POS_IN_W-1:0] pos,
		logic [TYPE_W-1:0] ptype, logic [TAG_IN_W-1:0] tag,
		logic [TYPE_W-1:0] want, logic any);
		belt_req_t r;
		r.op               = op;
		r.data             = '0;
		r.data.position    = pos;
		r.data.piece_type  = ptype;
		r.data.piece_tag   = tag;
		r.data.wanted_type = want;
		r.data.match_any   = any;
		belt_requests.push_back(r);
		n_queued++;
	endfunction

	// Random request, aimed mostly at positions in use and at a few busy ones.
	function automatic void queue_random_req(int span, int hot);
		op_t op;
		int  r;
		int  pos;
		int  ptype;
		int  want;
		r = $urandom_range(0, 99);
		if (r < 40) op = OP_ADD;
		else if (r < 72) op = OP_REMOVE;
		else if (r < 94) op = OP_TICK;
		else op = OP_NOP;
		r = $urandom_range(0, 99);
		if (r < 10) pos = $urandom_range(0, MAX_POSITIONS - 1);
		else if (r < 55) pos = $urandom_range(0, span - 1);
		else pos = (hot + $urandom_range(0, 3)) % span;
		ptype = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
			: $urandom_range(1, TYPE_COUNT);
		want = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7)
			: $urandom_range(1, TYPE_COUNT);
		queue_req(op, POS_IN_W'(pos), TYPE_W'(ptype),
			TAG_IN_W'($urandom_range(0, 16'hFFFF)), TYPE_W'(want),
			$urandom_range(0, 99) < 35);
	endfunction

	// Hold the sender back until every result has come out.
	task automatic wait_belt_idle();
		do @(negedge clk); while (n_accepted != n_queued || belt_answers.size() != 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_belt_length(logic [CFG_W-1:0] v);
		wait_belt_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_lengths++;
	endtask

	// Request driver: a request stays offered until it is taken.
	always @(negedge clk) begin
		belt_req_t r;
		if (arst_n && (!s_tvalid || req_fired)) begin
			if (tx_gap > 0) begin
				s_tvalid <= 1'b0;
				tx_gap--;
			end else if (belt_requests.size() != 0) begin
				r = belt_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.op;
				s_tdata  <= r.data;
				tx_gap   = draw_gap();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls plus one long hold on request.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (rx_gap > 0) begin
			m_tready <= 1'b0;
			rx_gap--;
		end else begin
			m_tready <= 1'b1;
			rx_gap = draw_gap();
		end
	end

	// Monitor: check each result, then predict for each accepted request.
	always @(posedge clk) begin
		out_data_t got;
		out_data_t want;
		req_fired = 1'b0;
		if (arst_n) begin
			if (cfg_we) begin
				belt_len_q = cfg_wdata;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (belt_answers.size() == 0) begin
					$error("result with no request waiting: %h", m_tdata);
					err_cnt++;
				end else begin
					want = belt_answers.pop_front();
					check_field("status", CNT_W'(want.status), CNT_W'(got.status));
					check_field("found_type", CNT_W'(want.found_type),
						CNT_W'(got.found_type));
					check_field("dropped_count", CNT_W'(want.dropped_count),
						CNT_W'(got.dropped_count));
					check_field("bin_total", want.bin_total, got.bin_total);
					check_field("type_bin_count", want.type_bin_count, got.type_bin_count);
					n_checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				belt_answers.push_back(belt_apply(op_t'(s_tuser), in_data_t'(s_tdata)));
				if (s_tuser == OP_TICK) n_ticks++;
				n_accepted++;
				req_fired = 1'b1;
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout: %0d requests accepted, %0d results still owed.",
				n_accepted, belt_answers.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Stimulus sequence.
	initial begin
		int span;
		int hot;
		belt_len_q  = 6'd32;
		bin_all_cnt = '0;
		for (int i = 0; i < MAX_POSITIONS; i++) begin
			cell_fill[i] = '0;
			for (int k = 0; k < SLOT_CAPACITY; k++) begin
				cell_type[i][k] = '0;
				cell_tag[i][k]  = '0;
			end
		end
		for (int t = 0; t < TYPE_COUNT; t++) begin
			bin_type_cnt[t] = '0;
		end
		phase_len[7] = CFG_W'($urandom_range(3, 31));

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Fill position 0 to capacity, then overflow it.
		queue_req(OP_ADD, 0, 1, 16'hFFFF, 0, 0);
		queue_req(OP_ADD, 0, 2, 16'h0001, 0, 0);
		queue_req(OP_ADD, 0, 3, 16'h8000, 0, 0);
		queue_req(OP_ADD, 0, 4, 16'h1234, 0, 0);
		queue_req(OP_ADD, 0, 1, 16'h5555, 0, 0);
		// Removes by type, a missing type, and by any type.
		queue_req(OP_REMOVE, 0, 3, 0, 3, 0);
		queue_req(OP_REMOVE, 0, 0, 0, 7, 0);
		queue_req(OP_REMOVE, 0, 1, 0, 0, 1);
		// Uncounted types at the last position; wanted type zero finds a type zero piece.
		queue_req(OP_ADD, 31, 0, 16'h0000, 0, 0);
		queue_req(OP_ADD, 31, 7, 16'hABCD, 0, 0);
		queue_req(OP_ADD, 31, 5, 16'h7FFF, 0, 0);
		queue_req(OP_REMOVE, 31, 0, 0, 0, 0);
		queue_req(OP_TICK, 0, 4, 0, 0, 0);
		queue_req(OP_REMOVE, 31, 0, 0, 0, 0);
		queue_req(OP_NOP, 31, 2, 16'hFFFF, 7, 1);
		queue_req(OP_REMOVE, 1, 2, 0, 2, 0);

		// A zero length behaves as a single position.
		set_belt_length(6'd0);
		queue_req(OP_ADD, 1, 2, 16'h00FF, 0, 0);
		queue_req(OP_REMOVE, 5, 0, 0, 0, 1);
		queue_req(OP_ADD, 0, 2, 16'hFF00, 0, 0);
		queue_req(OP_ADD, 0, 6, 16'h0F0F, 0, 0);
		queue_req(OP_TICK, 0, 2, 0, 0, 0);
		queue_req(OP_REMOVE, 0, 2, 0, 0, 1);

		// Random phases over several lengths; belt contents carry across them.
		for (int ph = 0; ph < 10; ph++) begin
			set_belt_length(phase_len[ph]);
			@(posedge clk);
			no_idle = (ph == 5);
			if (ph == 3) hold_request = HOLD_CYCLES;
			span = span_of(phase_len[ph]);
			hot  = $urandom_range(0, span - 1);
			repeat (PHASE_ITEMS) queue_random_req(span, hot);
		end

		wait_belt_idle();
		repeat (8) @(negedge clk);
		$display("Checked %0d results from %0d requests, %0d of them ticks,",
			n_checked, n_accepted, n_ticks);
		$display("over %0d belt length settings; %0d pieces reached the bin.",
			n_lengths + 1, bin_all_cnt);
		if (err_cnt == 0 && belt_answers.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== conveyor_slot_tracker.f =====
rtl/cst_pkg.sv
rtl/cst_cell.sv
rtl/cst_bin.sv
rtl/conveyor_slot_tracker.sv
rtl/cst_checker.sv
tb/tb_top.sv
